### rtl/pwbe_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-width bit expander package
// Shared widths, register indexes, reset values, the packer result type and the run clamp.
// ----------------------------------------------------------------------------
package pwbe_pkg;

   // Widths of the item fields.
   localparam int unsigned PayloadWidth = 8;
   localparam int unsigned CountWidth   = 4;
   localparam int unsigned TotalWidth   = 16;
   localparam int unsigned RunWidth     = 4;
   localparam int unsigned SlotsPerByte = 8;

   // Configuration register indexes.
   localparam logic [1:0] REG_ONE_HIGH  = 2'd0;
   localparam logic [1:0] REG_ONE_LOW   = 2'd1;
   localparam logic [1:0] REG_ZERO_HIGH = 2'd2;
   localparam logic [1:0] REG_ZERO_LOW  = 2'd3;

   // Reset values of the run-length registers.
   localparam logic [RunWidth-1:0] ONE_HIGH_RESET  = 4'd2;
   localparam logic [RunWidth-1:0] ONE_LOW_RESET   = 4'd1;
   localparam logic [RunWidth-1:0] ZERO_HIGH_RESET = 4'd1;
   localparam logic [RunWidth-1:0] ZERO_LOW_RESET  = 4'd2;

   // Outcome of one pass through the slot packer.
   typedef struct packed {
      logic [3:0] take;        // slots appended in this pass, 1..8
      logic [7:0] merged;      // slot byte after appending
      logic [2:0] next_count;  // slots held afterwards (zero when full)
      logic       full;        // the byte now holds eight slots
   } pack_result_type;

   // A run length of zero counts as one, anything above eight as eight.
   function automatic logic [RunWidth-1:0] clamp_run(input logic [RunWidth-1:0] v);
      logic [RunWidth-1:0] r;
      if (v == 4'd0) begin
         r = 4'd1;
      end else if (v > 4'd8) begin
         r = 4'd8;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### rtl/pwbe_slot_packer.sv
// ----------------------------------------------------------------------------
// Slot packer
// Appends as much of the current run as fits into the partial slot byte.
// ----------------------------------------------------------------------------
module pwbe_slot_packer (
   input  logic [7:0]               pending_slots,
   input  logic [2:0]               pending_count,
   input  logic [3:0]               run_left,
   input  logic                     level,
   output pwbe_pkg::pack_result_type result
);

   logic [3:0] avail;
   logic [3:0] take;
   logic [3:0] fill;
   logic [7:0] mask;

   // Room left in the byte and the part of the run that fits.
   assign avail = 4'd8 - {1'b0, pending_count};
   assign take  = (run_left < avail) ? run_left : avail;
   assign fill  = {1'b0, pending_count} + take;

   // Set the slots from the current fill position up to the new fill level.
   assign mask = (8'hFF >> pending_count) & ~(8'hFF >> fill);

   always_comb begin
      result.take       = take;
      result.merged     = level ? (pending_slots | mask) : pending_slots;
      result.next_count = fill[2:0];
      result.full       = (fill == 4'd8);
   end

endmodule

### rtl/pulse_width_bit_expander.sv
// ----------------------------------------------------------------------------
// Pulse-width bit expander
// Expands payload bits into runs of high and low slots, packed into bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req     | in        | tdata: payload_byte[7:0], bit_count[11:8]; tlast: final_item
//  rsp     | out       | tdata: slot_byte[7:0], valid_slots[11:8], total_slots[27:12];
//          |           | tlast: frame_end
//  csr     | in        | write enable, register index, 4-bit run length
//
//  An item is loaded from ST_IDLE and then worked off by packer passes in ST_RUN:
//  each run needs one pass, or two when it crosses a byte boundary, so up to 32
//  passes for eight bits; the closing partial byte of a frame goes out from ST_FLUSH.
//  The shared slot packer handles one run fragment per cycle.
//  Every pass, and the closing byte, waits while the result register still
//  holds an item that the receiver has not taken.
//  Reset is synchronous and returns the run lengths to their defaults.
// ----------------------------------------------------------------------------
module pulse_width_bit_expander (
   input  logic        clock,
   input  logic        reset,
   // Configuration writes.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // payload_byte[7:0], bit_count[11:8], zero fill
   input  logic        req_tlast,   // final_item
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // slot_byte[7:0], valid_slots[11:8],
                                    // total_slots[27:12], zero fill
   output logic        rsp_tlast    // frame_end
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type   state_ff, state_in;

   logic [3:0]  one_high_ff, one_low_ff, zero_high_ff, zero_low_ff;

   logic [7:0]  bits_ff, bits_in;
   logic [3:0]  bits_left_ff, bits_left_in;
   logic        phase_high_ff, phase_high_in;
   logic [3:0]  run_left_ff, run_left_in;
   logic        final_ff, final_in;

   logic [7:0]  pending_ff, pending_in;
   logic [2:0]  count_ff, count_in;
   logic [15:0] total_ff, total_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_slot_ff, rsp_slot_in;
   logic [3:0]  rsp_count_ff, rsp_count_in;
   logic [15:0] rsp_total_ff, rsp_total_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_accept;
   logic        out_free;
   logic [3:0]  req_bits;
   logic [3:0]  hi_first, lo_cur, hi_next;
   logic [3:0]  run_rem;
   logic [16:0] total_sum;
   logic [15:0] total_sat;
   logic        item_done;

   pwbe_pkg::pack_result_type pack;

   // Shared packing unit, one run fragment per cycle while the result register is free.
   pwbe_slot_packer u_packer (
      .pending_slots (pending_ff),
      .pending_count (count_ff),
      .run_left      (run_left_ff),
      .level         (phase_high_ff),
      .result        (pack)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Bit count above eight counts as eight.
   assign req_bits = (req_tdata[11:8] > 4'd8) ? 4'd8 : req_tdata[11:8];

   // Run lengths for the first bit of a new item, the current bit and the next.
   assign hi_first = req_tdata[7] ? pwbe_pkg::clamp_run(one_high_ff)
                                  : pwbe_pkg::clamp_run(zero_high_ff);
   assign lo_cur   = bits_ff[7] ? pwbe_pkg::clamp_run(one_low_ff)
                                : pwbe_pkg::clamp_run(zero_low_ff);
   assign hi_next  = bits_ff[6] ? pwbe_pkg::clamp_run(one_high_ff)
                                : pwbe_pkg::clamp_run(zero_high_ff);

   // Progress of the current pass.
   assign run_rem   = run_left_ff - pack.take;
   assign item_done = (run_rem == 4'd0) && !phase_high_ff && (bits_left_ff == 4'd1);
   assign total_sum = {1'b0, total_ff} + {13'd0, pack.take};
   assign total_sat = total_sum[16] ? 16'hFFFF : total_sum[15:0];

   // Sequencer and packing state.
   always_comb begin
      state_in      = state_ff;
      bits_in       = bits_ff;
      bits_left_in  = bits_left_ff;
      phase_high_in = phase_high_ff;
      run_left_in   = run_left_ff;
      final_in      = final_ff;
      pending_in    = pending_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               bits_in       = req_tdata[7:0];
               bits_left_in  = req_bits;
               phase_high_in = 1'b1;
               run_left_in   = hi_first;
               final_in      = req_tlast;
               if (req_bits != 4'd0) begin
                  state_in = ST_RUN;
               end else if (req_tlast) begin
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_RUN: begin
            if (out_free) begin
               total_in   = total_sat;
               pending_in = pack.full ? 8'd0 : pack.merged;
               count_in   = pack.next_count;

               // A full byte goes out; it closes the frame if nothing follows.
               if (pack.full) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = pack.merged;
                  rsp_count_in = 4'd8;
                  rsp_total_in = total_sat;
                  rsp_last_in  = final_ff && item_done;
               end

               // Step through the runs and the bits.
               if (run_rem != 4'd0) begin
                  run_left_in = run_rem;
               end else if (phase_high_ff) begin
                  phase_high_in = 1'b0;
                  run_left_in   = lo_cur;
               end else if (bits_left_ff != 4'd1) begin
                  bits_in       = {bits_ff[6:0], 1'b0};
                  bits_left_in  = bits_left_ff - 4'd1;
                  phase_high_in = 1'b1;
                  run_left_in   = hi_next;
               end else if (final_ff && pack.full) begin
                  pending_in = 8'd0;
                  count_in   = 3'd0;
                  total_in   = 16'd0;
                  state_in   = ST_IDLE;
               end else if (final_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            // Close the frame with the partial byte, possibly empty.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = pending_ff;
               rsp_count_in = {1'b0, count_ff};
               rsp_total_in = total_ff;
               rsp_last_in  = 1'b1;
               pending_in   = 8'd0;
               count_in     = 3'd0;
               total_in     = 16'd0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 8'd0;
         count_ff     <= 3'd0;
         total_ff     <= 16'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
      end
   end

   // Item payload and result register.
   always_ff @(posedge clock) begin
      bits_ff       <= bits_in;
      bits_left_ff  <= bits_left_in;
      phase_high_ff <= phase_high_in;
      run_left_ff   <= run_left_in;
      final_ff      <= final_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Run-length registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff  <= pwbe_pkg::ONE_HIGH_RESET;
         one_low_ff   <= pwbe_pkg::ONE_LOW_RESET;
         zero_high_ff <= pwbe_pkg::ZERO_HIGH_RESET;
         zero_low_ff  <= pwbe_pkg::ZERO_LOW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            pwbe_pkg::REG_ONE_HIGH:  one_high_ff  <= csr_wdata;
            pwbe_pkg::REG_ONE_LOW:   one_low_ff   <= csr_wdata;
            pwbe_pkg::REG_ZERO_HIGH: zero_high_ff <= csr_wdata;
            pwbe_pkg::REG_ZERO_LOW:  zero_low_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_total_ff, rsp_count_ff, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/pwbe_checker.sv
// ----------------------------------------------------------------------------
// Pulse-width bit expander checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pwbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result item holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // Only the closing item of a frame may carry a partial byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:8] != 4'd8) |-> rsp_tlast && (rsp_tdata[11:8] < 4'd8))
      else $error("partial slot byte outside frame end");

   // Slots beyond the valid count are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:8] < 4'd8) |->
         ((rsp_tdata[7:0] & (8'hFF >> rsp_tdata[11:8])) == 8'd0))
      else $error("unused slots not cleared");

   // A full byte always follows at least eight counted slots.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:8] == 4'd8) |-> (rsp_tdata[27:12] >= 16'd8))
      else $error("slot total below full byte count");

endmodule

bind pulse_width_bit_expander pwbe_checker u_pwbe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### dv/pwbe_slot_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Slot expansion scoreboard
// Predicts the packed slot bytes for each accepted payload item and checks
// every result item of the expander against the oldest prediction.
// ----------------------------------------------------------------------------
package pwbe_slot_scoreboard_pkg;

   // One result item, field by field.
   typedef struct packed {
      logic [7:0]  slot_byte;
      logic [3:0]  valid_slots;
      logic        frame_end;
      logic [15:0] total_slots;
   } slot_word_type;

   class slot_scoreboard;

      // Run lengths as written, before clamping.
      logic [pwbe_pkg::RunWidth-1:0] run_reg [4];

      // Frame state: the byte being filled and the slot total of the frame.
      logic [7:0]  partial_byte;
      int unsigned partial_count;
      logic [15:0] frame_slots;

      slot_word_type expected_words [$];

      int unsigned errors;
      int unsigned items_noted;
      int unsigned words_checked;
      int unsigned frames_closed;
      int unsigned reg_writes;
      int unsigned most_words;
      int unsigned saturated_frames;
      int unsigned words_this_item;

      function new();
         run_reg[pwbe_pkg::REG_ONE_HIGH]  = pwbe_pkg::ONE_HIGH_RESET;
         run_reg[pwbe_pkg::REG_ONE_LOW]   = pwbe_pkg::ONE_LOW_RESET;
         run_reg[pwbe_pkg::REG_ZERO_HIGH] = pwbe_pkg::ZERO_HIGH_RESET;
         run_reg[pwbe_pkg::REG_ZERO_LOW]  = pwbe_pkg::ZERO_LOW_RESET;
         partial_byte  = 8'h00;
         partial_count = 0;
         frame_slots   = 16'h0000;
      endfunction

      function void write_reg(input logic [1:0] index,
                              input logic [pwbe_pkg::RunWidth-1:0] value);
         run_reg[index] = value;
         reg_writes++;
      endfunction

      // A run of zero slots counts as one, anything beyond a byte as eight.
      function int unsigned run_length(input logic [pwbe_pkg::RunWidth-1:0] value);
         if (value == 0) begin
            return 1;
         end else if (value > pwbe_pkg::SlotsPerByte) begin
            return pwbe_pkg::SlotsPerByte;
         end
         return 32'(value);
      endfunction

      // Append one slot; a byte that fills up becomes a result at once.
      function void add_slot(input bit level);
         if (frame_slots != 16'hFFFF) begin
            frame_slots++;
         end
         if (level) begin
            partial_byte[7 - partial_count] = 1'b1;
         end
         partial_count++;
         if (partial_count == pwbe_pkg::SlotsPerByte) begin
            expected_words.push_back({partial_byte, 4'd8, 1'b0, frame_slots});
            words_this_item++;
            partial_byte  = 8'h00;
            partial_count = 0;
         end
      endfunction

      // Expand an accepted payload item into the result items it causes.
      function void note_item(input logic [7:0] payload, input logic [3:0] bit_count,
                              input logic final_item);
         int unsigned   bits_used;
         int unsigned   high_len;
         int unsigned   low_len;
         bit            level;
         slot_word_type closing;
         words_this_item = 0;
         bits_used = (bit_count > 4'd8) ? 8 : 32'(bit_count);
         for (int i = 0; i < bits_used; i++) begin
            level    = payload[7 - i];
            high_len = run_length(level ? run_reg[pwbe_pkg::REG_ONE_HIGH]
                                        : run_reg[pwbe_pkg::REG_ZERO_HIGH]);
            low_len  = run_length(level ? run_reg[pwbe_pkg::REG_ONE_LOW]
                                        : run_reg[pwbe_pkg::REG_ZERO_LOW]);
            repeat (high_len) add_slot(1'b1);
            repeat (low_len) add_slot(1'b0);
         end
         // Close the frame: flush a partial byte, mark the byte just emitted,
         // or send an empty marker when the item produced nothing at all.
         if (final_item) begin
            if (partial_count != 0) begin
               expected_words.push_back({partial_byte, 4'(partial_count), 1'b1, frame_slots});
               words_this_item++;
            end else if (words_this_item != 0) begin
               closing = expected_words.pop_back();
               closing.frame_end = 1'b1;
               expected_words.push_back(closing);
            end else begin
               expected_words.push_back({8'h00, 4'd0, 1'b1, frame_slots});
               words_this_item++;
            end
            if (frame_slots == 16'hFFFF) begin
               saturated_frames++;
            end
            frames_closed++;
            partial_byte  = 8'h00;
            partial_count = 0;
            frame_slots   = 16'h0000;
         end
         items_noted++;
         if (words_this_item > most_words) begin
            most_words = words_this_item;
         end
      endfunction

      function void compare_field(input string field_name, input int unsigned want,
                                  input int unsigned got, input longint unsigned at_ns);
         if (want != got) begin
            errors++;
            $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     at_ns, field_name, want, got);
         end
      endfunction

      // Check one accepted result item against the oldest prediction.
      function void check_word(input slot_word_type actual, input longint unsigned at_ns);
         slot_word_type want;
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0d ns: result 0x%0h arrived with nothing expected, expected none",
                     at_ns, actual);
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         compare_field("slot_byte", want.slot_byte, actual.slot_byte, at_ns);
         compare_field("valid_slots", want.valid_slots, actual.valid_slots, at_ns);
         compare_field("frame_end", want.frame_end, actual.frame_end, at_ns);
         compare_field("total_slots", want.total_slots, actual.total_slots, at_ns);
      endfunction

      function int unsigned outstanding();
         return expected_words.size();
      endfunction

   endclass

endpackage

### dv/pulse_width_bit_expander_tb.sv
// ----------------------------------------------------------------------------
// Pulse-width bit expander testbench
// Drives payload items and run-length settings into the expander, predicts
// the packed slot bytes in a scoreboard and checks every result item, under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module pulse_width_bit_expander_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int unsigned DRAIN_CYCLES   = 64;
   localparam int unsigned HOLDOFF_CYCLES = 400;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned PHASE_ITEMS    = 40;
   localparam int unsigned LONG_FRAME     = 80;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_index   = pwbe_pkg::REG_ONE_HIGH;
   logic [3:0]  csr_wdata   = 4'd0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = 16'h0000;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   pwbe_slot_scoreboard_pkg::slot_scoreboard slot_sb;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          holdoff_arm    = 1'b0;
   bit          holdoff_done   = 1'b0;
   int unsigned holdoff_left   = 0;

   pulse_width_bit_expander dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // payload_byte[7:0], bit_count[11:8], zero fill
      .req_tlast  (req_tlast),    // final_item
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // slot_byte[7:0], valid_slots[11:8], total_slots[27:12]
      .rsp_tlast  (rsp_tlast)     // frame_end
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off counted here when armed.
   always @(negedge clock) begin
      if (holdoff_arm && !holdoff_done) begin
         holdoff_left = HOLDOFF_CYCLES;
         holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result monitor: every accepted result item goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         slot_sb.check_word({rsp_tdata[7:0], rsp_tdata[11:8], rsp_tlast, rsp_tdata[27:12]},
                            $time);
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 72;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 72;
         end
         default: begin
            send_idle_pct  = 11;
            recv_stall_pct = 11;
         end
      endcase
   endtask

   // Write one register; the enable is left high for a following write.
   task automatic write_reg(input logic [1:0] index, input logic [3:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      slot_sb.write_reg(index, value);
   endtask

   task automatic configure(input logic [3:0] one_high, input logic [3:0] one_low,
                            input logic [3:0] zero_high, input logic [3:0] zero_low);
      write_reg(pwbe_pkg::REG_ONE_HIGH, one_high);
      write_reg(pwbe_pkg::REG_ONE_LOW, one_low);
      write_reg(pwbe_pkg::REG_ZERO_HIGH, zero_high);
      write_reg(pwbe_pkg::REG_ZERO_LOW, zero_low);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Offer one item after optional idle cycles and wait until it is taken.
   task automatic send_item(input logic [7:0] payload, input logic [3:0] bit_count,
                            input logic final_item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, bit_count, payload};
      req_tlast  <= final_item;
      do @(posedge clock); while (!req_tready);
      slot_sb.note_item(payload, bit_count, final_item);
   endtask

   // Stop offering, let every expected result arrive, then allow the block
   // time to finish any item that produces no result of its own.
   task automatic finish_phase();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (slot_sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Run lengths: mostly legal, with zero and oversized values mixed in.
   function automatic logic [3:0] pick_run();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return 4'd0;
      if (roll < 20) return 4'($urandom_range(15, 9));
      if (roll < 30) return 4'd8;
      return 4'($urandom_range(8, 1));
   endfunction

   // Bit counts: mostly legal, with empty and oversized counts mixed in.
   function automatic logic [3:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return 4'd0;
      if (roll < 12) return 4'($urandom_range(15, 9));
      return 4'($urandom_range(8, 1));
   endfunction

   // Whole frames of random length and content, each closed by a final item.
   task automatic send_random_frames(input int unsigned item_total);
      int unsigned left;
      int unsigned frame_len;
      left = item_total;
      while (left > 0) begin
         frame_len = $urandom_range(12, 1);
         if (frame_len > left) frame_len = left;
         for (int k = 0; k < frame_len; k++) begin
            send_item(8'($urandom_range(255)), pick_count(), k == frame_len - 1);
         end
         left -= frame_len;
      end
   endtask

   // Hard limit on the run.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      slot_sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset run lengths: three slots per bit, so eight bits fill three bytes.
      set_idling(IDLE_NONE);
      send_item(8'hFF, 4'd8, 1'b0);
      send_item(8'h00, 4'd8, 1'b0);
      send_item(8'hA5, 4'd8, 1'b1);    // frame ends exactly on a full byte
      send_item(8'h5A, 4'd0, 1'b1);    // empty frame: bare end marker
      send_item(8'h3C, 4'd0, 1'b0);    // no bits, no result
      send_item(8'h81, 4'd15, 1'b1);   // oversized count acts as eight
      send_item(8'h80, 4'd1, 1'b1);    // partial byte flushed
      send_item(8'h7E, 4'd9, 1'b0);
      send_item(8'h00, 4'd1, 1'b1);
      finish_phase();

      // Zero and oversized run lengths are clamped.
      configure(4'd0, 4'd15, 4'd0, 4'd15);
      send_item(8'hC3, 4'd8, 1'b0);
      send_item(8'hFF, 4'd4, 1'b1);
      finish_phase();

      configure(4'd8, 4'd8, 4'd8, 4'd8);
      send_item(8'hFF, 4'd8, 1'b0);
      send_item(8'h00, 4'd8, 1'b1);
      finish_phase();

      configure(4'd15, 4'd0, 4'd15, 4'd0);
      send_item(8'h01, 4'd8, 1'b1);
      send_item(8'hAA, 4'd3, 1'b0);
      send_item(8'h55, 4'd7, 1'b1);
      finish_phase();

      configure(4'd1, 4'd1, 4'd1, 4'd1);
      send_item(8'hFF, 4'd8, 1'b1);
      send_item(8'h00, 4'd8, 1'b1);
      send_item(8'hA0, 4'd3, 1'b1);
      finish_phase();

      // Random frames under each idling pattern, with fresh run lengths.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idling(idle_mode_type'(phase % 4));
         configure(pick_run(), pick_run(), pick_run(), pick_run());
         // Hold the result side off for a long stretch so the block backs up.
         if (phase == 4) holdoff_arm = 1'b1;
         send_random_frames(PHASE_ITEMS);
         finish_phase();
      end

      // One long frame with the widest runs: every item gives its most results.
      set_idling(IDLE_NONE);
      configure(4'd8, 4'd8, 4'd8, 4'd8);
      repeat (LONG_FRAME - 1) send_item(8'($urandom_range(255)), 4'd8, 1'b0);
      send_item(8'($urandom_range(255)), 4'd8, 1'b1);
      finish_phase();

      $display("Run covered %0d items in %0d frames, %0d results checked, %0d register writes.",
               slot_sb.items_noted, slot_sb.frames_closed, slot_sb.words_checked,
               slot_sb.reg_writes);
      $display("Most results from one item: %0d; frames reaching the slot limit: %0d.",
               slot_sb.most_words, slot_sb.saturated_frames);
      if (slot_sb.errors == 0 && slot_sb.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
